@@ rtl/core/multirotor_motor_mixer_assert.svh @@
// Assertion macros shared by the motor mixer RTL.
// Depends on nothing; included by files that check their own logic.
`ifndef MULTIROTOR_MOTOR_MIXER_ASSERT_SVH
`define MULTIROTOR_MOTOR_MIXER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MMM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("motor mixer check failed");

// next-cycle implication, disabled during reset
`define MMM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("motor mixer check failed");

`endif

@@ rtl/core/mmm_pkg.sv @@
// Types, constants and mixing tables of the multirotor motor mixer.
// Depends on nothing; used by the mixer, its front, queue and back, and the testbench.
package mmm_pkg;

   localparam int MAX_MOTORS_DEF = 6;
   localparam logic [11:0] IDLE_PULSE = 12'd1000;

   localparam int FRAME_COUNT   = 9;
   localparam int TABLE_MOTORS  = 6;
   localparam int MIDX_W        = 3;
   localparam int MIX_W         = 16;
   localparam int REG_INDEX_W   = 3;
   localparam int RECIP_SHIFT   = 17;
   localparam logic [15:0] RECIP_THIRD = 16'd43691;

   localparam logic [REG_INDEX_W-1:0] REG_FRAME_TYPE   = 3'd0;
   localparam logic [REG_INDEX_W-1:0] REG_YAW_REVERSE  = 3'd1;
   localparam logic [REG_INDEX_W-1:0] REG_MIN_THROTTLE = 3'd2;
   localparam logic [REG_INDEX_W-1:0] REG_MAX_THROTTLE = 3'd3;
   localparam logic [REG_INDEX_W-1:0] REG_MIN_CHECK    = 3'd4;
   localparam logic [REG_INDEX_W-1:0] REG_MOTOR_STOP   = 3'd5;
   localparam logic [REG_INDEX_W-1:0] REG_MIN_COMMAND  = 3'd6;

   localparam int FRAME_MOTORS [FRAME_COUNT] = '{2, 3, 4, 4, 4, 6, 6, 6, 4};

   localparam int COEF_ROLL [FRAME_COUNT][TABLE_MOTORS] = '{
      '{ 24, -24,   0,   0,   0,   0},
      '{ 24, -24,   0,   0,   0,   0},
      '{  0, -24,   0,  24,   0,   0},
      '{ 24, -24, -24,  24,   0,   0},
      '{ 24, -24,   0,   0,   0,   0},
      '{ 24, -24,   0,  24, -24,   0},
      '{  0, -24, -24,   0,  24,  24},
      '{ 21, -21, -21, -21,  21,  21},
      '{ 24, -24,   0,   0,   0,   0}
   };

   localparam int COEF_PITCH [FRAME_COUNT][TABLE_MOTORS] = '{
      '{  0,   0,   0,   0,   0,   0},
      '{-16, -16,  32,   0,   0,   0},
      '{-24,   0,  24,   0,   0,   0},
      '{-24, -24,  24,  24,   0,   0},
      '{-24, -24,  24,  24,   0,   0},
      '{-16, -16,  32, -16, -16,  32},
      '{-21, -21,  21,  21,  21, -21},
      '{-24, -24,   0,  24,  24,   0},
      '{-24, -24,  24,  24,   0,   0}
   };

   localparam int COEF_YAW [FRAME_COUNT][TABLE_MOTORS] = '{
      '{  0,   0,   0,   0,   0,   0},
      '{  0,   0,   0,   0,   0,   0},
      '{-24,  24, -24,  24,   0,   0},
      '{-24,  24, -24,  24,   0,   0},
      '{  0,   0, -24,  24,   0,   0},
      '{-24, -24,  24,  24,  24, -24},
      '{-24,  24, -24,  24, -24,  24},
      '{-24,  24, -24,  24, -24,  24},
      '{  0,   0,  24, -24,   0,   0}
   };

   typedef struct packed {
      logic [3:0]  frame_type;
      logic        yaw_reverse;
      logic [11:0] min_throttle;
      logic [11:0] max_throttle;
      logic [11:0] min_check;
      logic        motor_stop;
      logic [11:0] min_command;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      frame_type:   4'd3,
      yaw_reverse:  1'b0,
      min_throttle: 12'd1150,
      max_throttle: 12'd1850,
      min_check:    12'd1100,
      motor_stop:   1'b0,
      min_command:  12'd1000
   };

   typedef struct packed {
      logic [MIX_W-1:0]  excess;
      logic [MIDX_W-1:0] last_idx;
      logic              stick_low;
      logic              armed;
   } desc_type;

   typedef struct packed {
      logic              en;
      logic [MIDX_W-1:0] idx;
      logic [MIX_W-1:0]  data;
   } mix_wr_type;

   typedef struct packed {
      logic     en;
      desc_type desc;
   } push_type;

   typedef struct packed {
      logic              pop;
      logic [MIDX_W-1:0] idx;
   } rd_type;

   typedef struct packed {
      logic             vld;
      desc_type         desc;
      logic [MIX_W-1:0] mix;
   } head_type;

endpackage

@@ rtl/core/mmm_req_if.sv @@
// Control frame channel of the motor mixer: valid, ready and frame fields.
// Depends on nothing.
interface mmm_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] throttle_command;
   logic [11:0] pid_throttle;
   logic [11:0] pid_roll;
   logic [11:0] pid_pitch;
   logic [11:0] pid_yaw;
   logic [11:0] rc_throttle;
   logic        armed;

   modport source (output valid, throttle_command, pid_throttle, pid_roll, pid_pitch,
                   pid_yaw, rc_throttle, armed, input ready);
   modport sink (input valid, throttle_command, pid_throttle, pid_roll, pid_pitch,
                 pid_yaw, rc_throttle, armed, output ready);
endinterface

@@ rtl/core/mmm_rsp_if.sv @@
// Motor pulse channel of the motor mixer: valid, ready and pulse fields.
// Depends on nothing.
interface mmm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  motor_index;
   logic [11:0] motor_pulse;
   logic        last_motor;

   modport source (output valid, motor_index, motor_pulse, last_motor, input ready);
   modport sink (input valid, motor_index, motor_pulse, last_motor, output ready);
endinterface

@@ rtl/core/mmm_csr_if.sv @@
// Register write channel of the motor mixer: valid, ready, index and data.
// Depends on nothing.
interface mmm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  reg_index;
   logic [11:0] wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink (input valid, reg_index, wr_data, output ready);
endinterface

@@ rtl/core/multirotor_motor_mixer.sv @@
// Multirotor motor mixer: n pulses per frame of a known type (n motors of the frame, 2 to 6).
// Frames are mixed one motor per cycle, queued, then sent one pulse per cycle while
// rsp is ready; a new frame waits until the last is mixed and the queue has room.
// Synchronous active-high reset clears control and loads register defaults.
// Depends on mmm_pkg, the channel interfaces, mmm_front, mmm_queue and mmm_back.
module multirotor_motor_mixer #(
   parameter int MAX_MOTORS = mmm_pkg::MAX_MOTORS_DEF
) (
   input logic        clock,
   input logic        reset,
   mmm_req_if.sink    req_if,
   mmm_rsp_if.source  rsp_if,
   mmm_csr_if.sink    csr_if
);
   import mmm_pkg::*;

   cfg_type cfg_ff, cfg_in;
   mix_wr_type mix_wr;
   push_type push;
   rd_type rd;
   head_type head;
   logic q_full;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.reg_index)
            REG_FRAME_TYPE:   cfg_in.frame_type   = csr_if.wr_data[3:0];
            REG_YAW_REVERSE:  cfg_in.yaw_reverse  = csr_if.wr_data[0];
            REG_MIN_THROTTLE: cfg_in.min_throttle = csr_if.wr_data;
            REG_MAX_THROTTLE: cfg_in.max_throttle = csr_if.wr_data;
            REG_MIN_CHECK:    cfg_in.min_check    = csr_if.wr_data;
            REG_MOTOR_STOP:   cfg_in.motor_stop   = csr_if.wr_data[0];
            REG_MIN_COMMAND:  cfg_in.min_command  = csr_if.wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mmm_front #(
      .MAX_MOTORS(MAX_MOTORS)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (req_if),
      .q_full(q_full),
      .mix_wr(mix_wr),
      .push  (push)
   );

   mmm_queue #(
      .MAX_MOTORS(MAX_MOTORS)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .mix_wr(mix_wr),
      .push  (push),
      .rd    (rd),
      .full  (q_full),
      .head  (head)
   );

   mmm_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg  (cfg_ff),
      .head (head),
      .rd   (rd),
      .rsp  (rsp_if)
   );

endmodule

@@ rtl/core/mmm_front.sv @@
// Front end of the motor mixer: takes a frame, mixes one motor per cycle.
// Depends on mmm_pkg and mmm_req_if; feeds mmm_queue.
module mmm_front #(
   parameter int MAX_MOTORS = mmm_pkg::MAX_MOTORS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  mmm_pkg::cfg_type    cfg,
   mmm_req_if.sink             req,
   input  logic                q_full,
   output mmm_pkg::mix_wr_type mix_wr,
   output mmm_pkg::push_type   push
);
   import mmm_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [MIDX_W-1:0] idx_ff, idx_in;
   logic [MIDX_W-1:0] last_ff, last_in;
   logic [11:0] cmd_ff, cmd_in;
   logic signed [11:0] pt_ff, pt_in, pr_ff, pr_in, pp_ff, pp_in, py_ff, py_in;
   logic stick_low_ff, stick_low_in, armed_ff, armed_in;

   logic signed [19:0] acc_ff, acc_in;
   logic s1_vld_ff, s1_vld_in, s1_last_ff, s1_last_in;
   logic [MIDX_W-1:0] s1_idx_ff, s1_idx_in;

   logic [31:0] prod_ff, prod_in;
   logic s2_vld_ff, s2_vld_in, s2_last_ff, s2_last_in, s2_neg_ff, s2_neg_in;
   logic [MIDX_W-1:0] s2_idx_ff, s2_idx_in;

   logic signed [MIX_W-1:0] top_ff, top_in;
   logic done_ff, done_in;

   logic accept, ft_ok;
   logic [3:0] nmot, n_eff;
   logic signed [6:0] c_r, c_p, c_y_raw, c_y;
   logic signed [13:0] thr_sum;
   logic signed [18:0] base, prod_r, prod_p, prod_y;
   logic [19:0] mag;
   logic [15:0] mag8;
   logic [MIX_W-2:0] quot;
   logic [MIX_W-1:0] mix_u;
   logic signed [MIX_W-1:0] mix_s;
   logic signed [MIX_W:0] top_x, hi_x;

   assign req.ready = (state_ff == ST_IDLE) && !q_full;
   assign accept    = req.valid && req.ready;
   assign ft_ok     = cfg.frame_type < 4'(FRAME_COUNT);
   assign nmot      = ft_ok ? 4'(FRAME_MOTORS[cfg.frame_type]) : 4'd0;
   assign n_eff     = (nmot > 4'(MAX_MOTORS)) ? 4'(MAX_MOTORS) : nmot;

   // stage 1: weighted sum in 1/24 units
   always_comb begin
      c_r     = 7'(COEF_ROLL[cfg.frame_type][idx_ff]);
      c_p     = 7'(COEF_PITCH[cfg.frame_type][idx_ff]);
      c_y_raw = 7'(COEF_YAW[cfg.frame_type][idx_ff]);
      c_y     = cfg.yaw_reverse ? -c_y_raw : c_y_raw;
      thr_sum = $signed({2'b00, cmd_ff}) + 14'(pt_ff);
      base    = 19'(thr_sum) * 19'sd24;
      prod_r  = 19'(c_r) * 19'(pr_ff);
      prod_p  = 19'(c_p) * 19'(pp_ff);
      prod_y  = 19'(c_y) * 19'(py_ff);
      acc_in  = 20'(base) + 20'(prod_r) + 20'(prod_p) + 20'(prod_y);
   end

   // stage 2: magnitude over 8, times reciprocal of 3
   always_comb begin
      mag     = acc_ff[19] ? 20'(-acc_ff) : 20'(acc_ff);
      mag8    = mag[18:3];
      prod_in = 32'(mag8) * 32'(RECIP_THIRD);
   end

   // stage 3: restore sign, store, track the largest mix
   always_comb begin
      quot   = prod_ff[31:RECIP_SHIFT];
      mix_u  = s2_neg_ff ? (~{1'b0, quot} + 16'd1) : {1'b0, quot};
      mix_s  = $signed(mix_u);
      top_in = top_ff;
      if (s2_vld_ff && ((s2_idx_ff == '0) || (mix_s > top_ff))) begin
         top_in = mix_s;
      end
      done_in = s2_vld_ff && s2_last_ff;
   end

   assign mix_wr.en   = s2_vld_ff;
   assign mix_wr.idx  = s2_idx_ff;
   assign mix_wr.data = mix_u;

   assign top_x = 17'(top_ff);
   assign hi_x  = $signed({5'b00000, cfg.max_throttle});

   assign push.en             = done_ff;
   assign push.desc.excess    = (top_x > hi_x) ? 16'(top_x - hi_x) : 16'd0;
   assign push.desc.last_idx  = last_ff;
   assign push.desc.stick_low = stick_low_ff;
   assign push.desc.armed     = armed_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      cmd_in       = cmd_ff;
      pt_in        = pt_ff;
      pr_in        = pr_ff;
      pp_in        = pp_ff;
      py_in        = py_ff;
      stick_low_in = stick_low_ff;
      armed_in     = armed_ff;
      s1_vld_in    = 1'b0;
      s1_idx_in    = idx_ff;
      s1_last_in   = (idx_ff == last_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in       = req.throttle_command;
               pt_in        = $signed(req.pid_throttle);
               pr_in        = $signed(req.pid_roll);
               pp_in        = $signed(req.pid_pitch);
               py_in        = $signed(req.pid_yaw);
               stick_low_in = req.rc_throttle < cfg.min_check;
               armed_in     = req.armed;
               idx_in       = '0;
               last_in      = 3'(n_eff - 4'd1);
               // drop frames of an unknown type
               if (ft_ok) begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            s1_vld_in = 1'b1;
            idx_in    = idx_ff + 3'd1;
            if (idx_ff == last_ff) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (done_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign s2_vld_in  = s1_vld_ff;
   assign s2_idx_in  = s1_idx_ff;
   assign s2_last_in = s1_last_ff;
   assign s2_neg_in  = acc_ff[19];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      last_ff      <= last_in;
      cmd_ff       <= cmd_in;
      pt_ff        <= pt_in;
      pr_ff        <= pr_in;
      pp_ff        <= pp_in;
      py_ff        <= py_in;
      stick_low_ff <= stick_low_in;
      armed_ff     <= armed_in;
      acc_ff       <= acc_in;
      s1_idx_ff    <= s1_idx_in;
      s1_last_ff   <= s1_last_in;
      prod_ff      <= prod_in;
      s2_idx_ff    <= s2_idx_in;
      s2_last_ff   <= s2_last_in;
      s2_neg_ff    <= s2_neg_in;
      top_ff       <= top_in;
   end

endmodule

@@ rtl/core/mmm_queue.sv @@
// Two-frame queue between front and back: frame records plus two banks of mixes.
// Depends on mmm_pkg and the assertion macro header.
`include "multirotor_motor_mixer_assert.svh"

module mmm_queue #(
   parameter int MAX_MOTORS = mmm_pkg::MAX_MOTORS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  mmm_pkg::mix_wr_type mix_wr,
   input  mmm_pkg::push_type   push,
   input  mmm_pkg::rd_type     rd,
   output logic                full,
   output mmm_pkg::head_type   head
);
   import mmm_pkg::*;

   localparam int MW    = $clog2(MAX_MOTORS);
   localparam int DEPTH = 2 << MW;

   logic [1:0] count_ff, count_in;
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   desc_type desc_ff [2];
   logic [MIX_W-1:0] mix_ff [DEPTH];
   logic empty;

   assign full  = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;

   assign head.vld  = !empty;
   assign head.desc = desc_ff[rd_ptr_ff];
   assign head.mix  = mix_ff[{rd_ptr_ff, rd.idx[MW-1:0]}];

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push.en) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (rd.pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      priority if (push.en && !rd.pop) begin
         count_in = count_ff + 2'd1;
      end else if (rd.pop && !push.en) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.en) begin
         desc_ff[wr_ptr_ff] <= push.desc;
      end
      if (mix_wr.en) begin
         mix_ff[{wr_ptr_ff, mix_wr.idx[MW-1:0]}] <= mix_wr.data;
      end
   end

   `MMM_ASSERT_IMP(a_push_room, clock, reset, push.en, !full)
   `MMM_ASSERT_IMP(a_pop_data, clock, reset, rd.pop, !empty)
   `MMM_ASSERT_IMP(a_write_room, clock, reset, mix_wr.en, !full)
   `MMM_ASSERT_NXT(a_count_up, clock, reset, push.en && !rd.pop, count_ff == $past(count_ff) + 2'd1)

endmodule

@@ rtl/core/mmm_back.sv @@
// Back end of the mixer: offsets, clamps, sends one pulse per cycle while ready.
// Depends on mmm_pkg and mmm_rsp_if; drains mmm_queue.
module mmm_back (
   input  logic              clock,
   input  logic              reset,
   input  mmm_pkg::cfg_type  cfg,
   input  mmm_pkg::head_type head,
   output mmm_pkg::rd_type   rd,
   mmm_rsp_if.source         rsp
);
   import mmm_pkg::*;

   logic [MIDX_W-1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [MIDX_W-1:0] out_idx_ff, out_idx_in;
   logic [11:0] out_pulse_ff, out_pulse_in;
   logic out_last_ff, out_last_in;

   logic adv, go, is_last;
   logic signed [MIX_W:0] adj, lo_x, hi_x;
   logic [11:0] pulse;

   assign adv     = !rsp_valid_ff || rsp.ready;
   assign go      = head.vld && adv;
   assign is_last = idx_ff == head.desc.last_idx;

   assign rd.idx = idx_ff;
   assign rd.pop = go && is_last;

   always_comb begin
      adj  = 17'($signed(head.mix)) - $signed({1'b0, head.desc.excess});
      lo_x = $signed({5'b00000, cfg.min_throttle});
      hi_x = $signed({5'b00000, cfg.max_throttle});
      priority if (!head.desc.armed) begin
         pulse = IDLE_PULSE;
      end else if (head.desc.stick_low) begin
         pulse = cfg.motor_stop ? cfg.min_command : cfg.min_throttle;
      end else if (adj < lo_x) begin
         pulse = cfg.min_throttle;
      end else if (adj > hi_x) begin
         pulse = cfg.max_throttle;
      end else begin
         pulse = adj[11:0];
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      out_idx_in   = out_idx_ff;
      out_pulse_in = out_pulse_ff;
      out_last_in  = out_last_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
         out_idx_in   = idx_ff;
         out_pulse_in = pulse;
         out_last_in  = is_last;
         idx_in       = is_last ? '0 : idx_ff + 3'd1;
      end else if (adv) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_idx_ff   <= out_idx_in;
      out_pulse_ff <= out_pulse_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.motor_index = out_idx_ff;
   assign rsp.motor_pulse = out_pulse_ff;
   assign rsp.last_motor  = out_last_ff;

endmodule

@@ tb/sv/mixer_check_pkg.sv @@
// Frame and pulse types, frame geometry table and the pulse scoreboard
// for the motor mixer testbench. Depends on mmm_pkg for register types and indexes.
package mixer_check_pkg;

   localparam int MOTOR_SLOTS = 6;
   localparam int TABLE_MOTORS = 6;
   localparam int COEF_UNIT = 24;
   localparam int IDLE_PULSE_WIDTH = 1000;
   localparam int REPORT_LIMIT = 10;

   localparam logic [3:0] FRAME_BI        = 4'd0;
   localparam logic [3:0] FRAME_TRI       = 4'd1;
   localparam logic [3:0] FRAME_QUAD_PLUS = 4'd2;
   localparam logic [3:0] FRAME_QUAD_X    = 4'd3;
   localparam logic [3:0] FRAME_Y4        = 4'd4;
   localparam logic [3:0] FRAME_Y6        = 4'd5;
   localparam logic [3:0] FRAME_HEX_PLUS  = 4'd6;
   localparam logic [3:0] FRAME_HEX_X     = 4'd7;
   localparam logic [3:0] FRAME_VTAIL4    = 4'd8;
   localparam int FRAME_KINDS = 9;

   localparam int FRAME_MOTOR_COUNT [FRAME_KINDS] = '{2, 3, 4, 4, 4, 6, 6, 6, 4};

   // roll, pitch, yaw weight per motor in 1/24 units
   localparam int MIX_COEF [FRAME_KINDS][TABLE_MOTORS][3] = '{
      '{'{24, 0, 0}, '{-24, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}},
      '{'{24, -16, 0}, '{-24, -16, 0}, '{0, 32, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}},
      '{'{0, -24, -24}, '{-24, 0, 24}, '{0, 24, -24}, '{24, 0, 24}, '{0, 0, 0}, '{0, 0, 0}},
      '{'{24, -24, -24}, '{-24, -24, 24}, '{-24, 24, -24}, '{24, 24, 24}, '{0, 0, 0},
        '{0, 0, 0}},
      '{'{24, -24, 0}, '{-24, -24, 0}, '{0, 24, -24}, '{0, 24, 24}, '{0, 0, 0}, '{0, 0, 0}},
      '{'{24, -16, -24}, '{-24, -16, -24}, '{0, 32, 24}, '{24, -16, 24}, '{-24, -16, 24},
        '{0, 32, -24}},
      '{'{0, -21, -24}, '{-24, -21, 24}, '{-24, 21, -24}, '{0, 21, 24}, '{24, 21, -24},
        '{24, -21, 24}},
      '{'{21, -24, -24}, '{-21, -24, 24}, '{-21, 0, -24}, '{-21, 24, 24}, '{21, 24, -24},
        '{21, 0, 24}},
      '{'{24, -24, 0}, '{-24, -24, 0}, '{0, 24, 24}, '{0, 24, -24}, '{0, 0, 0}, '{0, 0, 0}}
   };

   typedef struct {
      logic [11:0]        throttle_command;
      logic signed [11:0] pid_throttle;
      logic signed [11:0] pid_roll;
      logic signed [11:0] pid_pitch;
      logic signed [11:0] pid_yaw;
      logic [11:0]        rc_throttle;
      logic               armed;
   } control_frame_type;

   typedef struct packed {
      logic [2:0]  motor_index;
      logic [11:0] motor_pulse;
      logic        last_motor;
   } motor_pulse_type;

   class motor_pulse_board;
      mmm_pkg::cfg_type regs;
      motor_pulse_type expected_pulses[$];
      int mismatch_count;

      function new();
         regs.frame_type   = FRAME_QUAD_X;
         regs.yaw_reverse  = 1'b0;
         regs.min_throttle = 12'd1150;
         regs.max_throttle = 12'd1850;
         regs.min_check    = 12'd1100;
         regs.motor_stop   = 1'b0;
         regs.min_command  = 12'd1000;
         mismatch_count    = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [11:0] data);
         case (index)
            mmm_pkg::REG_FRAME_TYPE: regs.frame_type = data[3:0];
            mmm_pkg::REG_YAW_REVERSE: regs.yaw_reverse = data[0];
            mmm_pkg::REG_MIN_THROTTLE: regs.min_throttle = data;
            mmm_pkg::REG_MAX_THROTTLE: regs.max_throttle = data;
            mmm_pkg::REG_MIN_CHECK: regs.min_check = data;
            mmm_pkg::REG_MOTOR_STOP: regs.motor_stop = data[0];
            mmm_pkg::REG_MIN_COMMAND: regs.min_command = data;
            default: ;
         endcase
      endfunction

      function void note_frame(control_frame_type f);
         int motors, dir, base, top, m, lo, hi, kind;
         int mix [TABLE_MOTORS];
         motor_pulse_type p;
         if (regs.frame_type >= FRAME_KINDS) return;
         kind = int'(regs.frame_type);
         motors = FRAME_MOTOR_COUNT[kind];
         if (motors > MOTOR_SLOTS) motors = MOTOR_SLOTS;
         dir = regs.yaw_reverse ? -1 : 1;
         lo = int'(regs.min_throttle);
         hi = int'(regs.max_throttle);
         base = COEF_UNIT * (int'(f.throttle_command) + int'(f.pid_throttle));
         for (int i = 0; i < motors; i++) begin
            mix[i] = (base + MIX_COEF[kind][i][0] * int'(f.pid_roll)
                      + MIX_COEF[kind][i][1] * int'(f.pid_pitch)
                      + dir * MIX_COEF[kind][i][2] * int'(f.pid_yaw)) / COEF_UNIT;
         end
         top = mix[0];
         for (int i = 1; i < motors; i++)
            if (mix[i] > top) top = mix[i];
         for (int i = 0; i < motors; i++) begin
            m = mix[i];
            if (top > hi) m -= top - hi;
            if (m < lo) m = lo;
            else if (m > hi) m = hi;
            if (f.rc_throttle < regs.min_check)
               m = regs.motor_stop ? int'(regs.min_command) : lo;
            if (!f.armed) m = IDLE_PULSE_WIDTH;
            p.motor_index = i[2:0];
            p.motor_pulse = m[11:0];
            p.last_motor  = (i == motors - 1);
            expected_pulses.push_back(p);
         end
      endfunction

      function void check_pulse(motor_pulse_type got);
         motor_pulse_type want;
         if (expected_pulses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected pulse: motor %0d pulse %0d last %0d",
                        got.motor_index, got.motor_pulse, got.last_motor);
            return;
         end
         want = expected_pulses.pop_front();
         if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $write("pulse mismatch: expected motor %0d pulse %0d last %0d, ",
                      want.motor_index, want.motor_pulse, want.last_motor);
               $display("got motor %0d pulse %0d last %0d",
                        got.motor_index, got.motor_pulse, got.last_motor);
            end
         end
      endfunction

      function int pending();
         return expected_pulses.size();
      endfunction

      function bit failed();
         return (mismatch_count != 0) || (expected_pulses.size() != 0);
      endfunction
   endclass

endpackage

@@ tb/sv/tb.sv @@
// Top of the motor mixer testbench: drives control frames and register writes,
// predicts every motor pulse and checks it. Depends on mmm_pkg, the channel
// interfaces, mixer_check_pkg and multirotor_motor_mixer.
module tb;
   import mixer_check_pkg::*;

   localparam int DRAIN_CYCLES = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES = 16;
   localparam int ITEMS_PER_PHASE = 28;
   localparam int INVALID_PHASE = 12;
   localparam int IGNORED_ITEMS = 8;

   logic clock;
   logic reset;
   int src_idle_pct = 0;
   int sink_stall_pct = 0;
   mmm_pkg::cfg_type cfg;
   motor_pulse_board board = new();

   mmm_req_if req_if();
   mmm_rsp_if rsp_if();
   mmm_csr_if csr_if();

   multirotor_motor_mixer #(.MAX_MOTORS(MOTOR_SLOTS)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   always @(posedge clock) begin : observe
      control_frame_type seen_frame;
      motor_pulse_type seen_pulse;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            board.write_reg(csr_if.reg_index, csr_if.wr_data);
         if (req_if.valid && req_if.ready) begin
            seen_frame.throttle_command = req_if.throttle_command;
            seen_frame.pid_throttle     = req_if.pid_throttle;
            seen_frame.pid_roll         = req_if.pid_roll;
            seen_frame.pid_pitch        = req_if.pid_pitch;
            seen_frame.pid_yaw          = req_if.pid_yaw;
            seen_frame.rc_throttle      = req_if.rc_throttle;
            seen_frame.armed            = req_if.armed;
            board.note_frame(seen_frame);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            seen_pulse.motor_index = rsp_if.motor_index;
            seen_pulse.motor_pulse = rsp_if.motor_pulse;
            seen_pulse.last_motor  = rsp_if.last_motor;
            board.check_pulse(seen_pulse);
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   function automatic control_frame_type frame_of(int cmd, int pt, int pr, int pp, int py,
                                                  int rc, int armed);
      control_frame_type f;
      f.throttle_command = cmd[11:0];
      f.pid_throttle     = pt[11:0];
      f.pid_roll         = pr[11:0];
      f.pid_pitch        = pp[11:0];
      f.pid_yaw          = py[11:0];
      f.rc_throttle      = rc[11:0];
      f.armed            = armed[0];
      return f;
   endfunction

   function automatic int spread(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic control_frame_type random_frame();
      control_frame_type f;
      if ($urandom_range(3) == 0) begin
         f = frame_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
         f = frame_of(900 + $urandom_range(1100), spread(150), spread(500), spread(500),
                      spread(500), 1000 + $urandom_range(1100), $urandom_range(15) != 0);
      end
      return f;
   endfunction

   function automatic logic [11:0] pick_level(int typical, int span);
      case ($urandom_range(7))
         0: return 12'd0;
         1: return '1;
         2: return 12'($urandom_range(4095));
         default: return 12'(typical + $urandom_range(span));
      endcase
   endfunction

   task automatic set_idling(input int mode);
      case (mode)
         1: begin src_idle_pct = 68; sink_stall_pct = 0; end
         2: begin src_idle_pct = 0; sink_stall_pct = 68; end
         3: begin src_idle_pct = 27; sink_stall_pct = 27; end
         default: begin src_idle_pct = 0; sink_stall_pct = 0; end
      endcase
   endtask

   task automatic send_frame(input control_frame_type f);
      if ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_if.valid            <= 1'b1;
      req_if.throttle_command <= f.throttle_command;
      req_if.pid_throttle     <= f.pid_throttle;
      req_if.pid_roll         <= f.pid_roll;
      req_if.pid_pitch        <= f.pid_pitch;
      req_if.pid_yaw          <= f.pid_yaw;
      req_if.rc_throttle      <= f.rc_throttle;
      req_if.armed            <= f.armed;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [11:0] data);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= index;
      csr_if.wr_data   <= data;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   task automatic apply_config(input mmm_pkg::cfg_type c);
      write_reg(mmm_pkg::REG_FRAME_TYPE, {8'd0, c.frame_type});
      write_reg(mmm_pkg::REG_YAW_REVERSE, {11'd0, c.yaw_reverse});
      write_reg(mmm_pkg::REG_MIN_THROTTLE, c.min_throttle);
      write_reg(mmm_pkg::REG_MAX_THROTTLE, c.max_throttle);
      write_reg(mmm_pkg::REG_MIN_CHECK, c.min_check);
      write_reg(mmm_pkg::REG_MOTOR_STOP, {11'd0, c.motor_stop});
      write_reg(mmm_pkg::REG_MIN_COMMAND, c.min_command);
      csr_if.valid <= 1'b0;
   endtask

   // drop valid, wait out every pending pulse and the pipeline tail
   task automatic end_burst();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset                   <= 1'b1;
      req_if.valid            <= 1'b0;
      req_if.throttle_command <= '0;
      req_if.pid_throttle     <= '0;
      req_if.pid_roll         <= '0;
      req_if.pid_pitch        <= '0;
      req_if.pid_yaw          <= '0;
      req_if.rc_throttle      <= '0;
      req_if.armed            <= 1'b0;
      csr_if.valid            <= 1'b0;
      csr_if.reg_index        <= '0;
      csr_if.wr_data          <= '0;
      cfg = mmm_pkg::CFG_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      set_idling(0);
      send_frame(frame_of(1500, 0, 0, 0, 0, 1500, 1));
      send_frame(frame_of(0, -2048, -2048, -2048, -2048, 4095, 1));
      send_frame(frame_of(4095, 2047, 2047, 2047, 2047, 4095, 1));
      send_frame(frame_of(1500, 0, 300, -200, 100, 1500, 1));
      send_frame(frame_of(1500, 0, -2048, 2047, -2048, 2000, 1));
      send_frame(frame_of(1800, 100, 50, 60, 70, 1099, 1));
      send_frame(frame_of(1800, 100, 50, 60, 70, 1100, 1));
      send_frame(frame_of(1500, 0, 0, 0, 0, 0, 1));
      send_frame(frame_of(1500, 0, 10, 10, 10, 1500, 0));
      send_frame(frame_of(1500, 0, 0, 0, 0, 0, 0));
      end_burst();

      cfg.yaw_reverse = 1'b1;
      cfg.motor_stop  = 1'b1;
      cfg.min_command = '1;
      apply_config(cfg);
      send_frame(frame_of(1500, 0, 0, 0, 300, 1500, 1));
      send_frame(frame_of(1500, 0, 0, 0, 0, 0, 1));
      end_burst();

      // crossed limits
      cfg.yaw_reverse  = 1'b0;
      cfg.motor_stop   = 1'b0;
      cfg.min_throttle = 12'd1900;
      cfg.max_throttle = 12'd1200;
      apply_config(cfg);
      send_frame(frame_of(1000, 0, 0, 0, 0, 1500, 1));
      send_frame(frame_of(1500, 0, 0, 0, 0, 1500, 1));
      send_frame(frame_of(2500, 0, 0, 0, 0, 1500, 1));
      end_burst();

      cfg.min_throttle = 12'd1150;
      cfg.max_throttle = 12'd1850;
      for (int k = 0; k < FRAME_KINDS; k++) begin
         cfg.frame_type = k[3:0];
         apply_config(cfg);
         send_frame(frame_of(1400, 37, -413, 251, -97, 1500, 1));
         end_burst();
      end

      // unknown frame types give no pulses
      cfg.frame_type = FRAME_KINDS[3:0];
      apply_config(cfg);
      send_frame(frame_of(1500, 0, 0, 0, 0, 1500, 1));
      send_frame(frame_of(1500, 0, 0, 0, 0, 1500, 1));
      end_burst();
      cfg.frame_type = '1;
      apply_config(cfg);
      send_frame(frame_of(1500, 0, 0, 0, 0, 1500, 1));
      send_frame(frame_of(1500, 0, 0, 0, 0, 1500, 1));
      end_burst();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         cfg.frame_type   = (p < FRAME_KINDS) ? p[3:0] : 4'($urandom_range(FRAME_KINDS - 1));
         cfg.yaw_reverse  = 1'($urandom_range(1));
         cfg.min_throttle = pick_level(1000, 300);
         cfg.max_throttle = pick_level(1700, 300);
         cfg.min_check    = pick_level(1000, 200);
         cfg.motor_stop   = 1'($urandom_range(1));
         cfg.min_command  = pick_level(900, 200);
         if (p == 0) begin
            cfg.min_throttle = '0;
            cfg.max_throttle = '1;
            cfg.min_check    = '0;
            cfg.min_command  = '0;
         end else if (p == 1) begin
            cfg.min_throttle = '1;
            cfg.max_throttle = '0;
            cfg.min_check    = '1;
            cfg.min_command  = '1;
         end else if (p == INVALID_PHASE) begin
            cfg.frame_type = 4'($urandom_range(15, FRAME_KINDS));
         end
         apply_config(cfg);
         set_idling(p % 4);
         repeat ((p == INVALID_PHASE) ? IGNORED_ITEMS : ITEMS_PER_PHASE)
            send_frame(random_frame());
         end_burst();
      end

      if (board.failed())
         $display("== FAIL ==");
      else
         $display("== PASS ==");
      $finish;
   end

endmodule
